// ===== design/region_bucketed_hot_pc_profiler_assert.svh =====
// assertion macros for the profiler checker
`ifndef REGION_BUCKETED_HOT_PC_PROFILER_ASSERT_SVH
`define REGION_BUCKETED_HOT_PC_PROFILER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RBP_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define RBP_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ===== design/rbhpp_pkg.sv =====
// ---------------------------------------------------------------------------
// rbhpp_pkg
// shared types and constants of the region bucketed hot address profiler
// ---------------------------------------------------------------------------
package rbhpp_pkg;

	localparam int TABLE_SLOTS = 1024;
	localparam int TOP_RANKS = 12;
	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int REGION_COUNT = 5;
	localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
	localparam int HASH_SHIFT = 40;

	localparam logic [2:0] REG_KERNEL_BASE = 3'd0;
	localparam logic [2:0] REG_EXEC_BASE = 3'd1;
	localparam logic [2:0] REG_HIGH_BASE = 3'd2;
	localparam logic [2:0] REG_HIGH_LIMIT = 3'd3;
	localparam logic [2:0] REG_LOW_LIMIT = 3'd4;
	localparam logic [2:0] REG_INTERVAL = 3'd5;

	localparam logic [63:0] RST_KERNEL_BASE = 64'hFFFF800000000000;
	localparam logic [63:0] RST_EXEC_BASE = 64'h0000010000400000;
	localparam logic [63:0] RST_HIGH_BASE = 64'h0000010001000000;
	localparam logic [63:0] RST_HIGH_LIMIT = 64'h0000010200000000;
	localparam logic [63:0] RST_LOW_LIMIT = 64'h0000000100000000;
	localparam logic [63:0] RST_INTERVAL = 64'd200000000;

	localparam logic [1:0] REC_TOTAL = 2'd0;
	localparam logic [1:0] REC_REGION = 2'd1;
	localparam logic [1:0] REC_HOT = 2'd2;

	// output record, packed into tdata low field first
	typedef struct packed {
		logic        last;
		logic [63:0] value;
		logic [63:0] address;
		logic [3:0]  index;
		logic        final_res;
		logic [1:0]  record;
	} out_rec_t;

endpackage

// ===== design/rbhpp_table.sv =====
// ---------------------------------------------------------------------------
// rbhpp_table
// slot table: address, count and taken mark per slot, one read and one write each cycle
// ---------------------------------------------------------------------------
module rbhpp_table
	import rbhpp_pkg::*;
(
	input  logic              clk,
	input  logic              clr,
	input  logic [SLOT_W-1:0] raddr,
	output logic [63:0]       rd_addr,
	output logic [63:0]       rd_cnt,
	output logic              rd_taken,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  logic [63:0]       wr_addr,
	input  logic [63:0]       wr_cnt
);

	logic [63:0] addr_mem [TABLE_SLOTS];
	logic [63:0] cnt_mem [TABLE_SLOTS];
	logic        taken_mem [TABLE_SLOTS];

	// clr wipes the taken mark of one slot, a write sets it
	always_ff @(posedge clk) begin
		if (we) begin
			addr_mem[waddr] <= wr_addr;
			cnt_mem[waddr] <= wr_cnt;
		end
		if (clr || we) taken_mem[waddr] <= !clr;
		rd_addr <= addr_mem[raddr];
		rd_cnt <= cnt_mem[raddr];
		rd_taken <= taken_mem[raddr];
	end

endmodule

// ===== design/region_bucketed_hot_pc_profiler.sv =====
// ---------------------------------------------------------------------------
// region_bucketed_hot_pc_profiler
// counts block instructions by address region, kernel addresses by slot,
// and emits reports of totals and the hottest slots
// ---------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: pc, insn_count; tuser: kind
// m_axis    out  tdata: record, final_res, index, address, value; tlast: last
// cfg       in   cfg_we, cfg_idx, cfg_data
//
// a non-kernel event updates only the counters before the mark check; a kernel
// event is also hashed on one 32x32 multiplier, then each probe reads and checks a slot.
// a report sweeps the table once for each of up to TOP_RANKS ranks: each rank is
// one sweep of the table read port through one shared compare unit.
// after reset a clearing pass over every slot wipes the taken marks.
// a stalled output holds the sequencer; no new request is taken until the last record is loaded.
// ---------------------------------------------------------------------------
module region_bucketed_hot_pc_profiler
	import rbhpp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,   // pc[63:0], insn_count[75:64], zero fill
	input  logic         s_axis_tuser,   // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,   // record, final_res, index, address, value
	output logic         m_axis_tlast,   // last
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [63:0]  cfg_data
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_PROBE, ST_WAIT, ST_CHECK, ST_MARK,
		ST_EMIT, ST_SCAN, ST_SCAN_END, ST_DONE
	} state_t;

	state_t state_q;
	logic [63:0] kbase_q, ebase_q, hbase_q, hlim_q, llim_q, intv_q;
	logic [63:0] reg_cnt_q [REGION_COUNT];
	logic [63:0] total_q, mark_q;
	logic [63:0] pc_q, n_q, prod_q;
	logic [1:0] hstep_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] probes_q;
	logic fin_q;
	logic [2:0] rec_q;
	logic [3:0] rank_q;
	logic [SLOT_W-1:0] scan_q;
	logic [63:0] best_q, best_addr_q, prev_cnt_q;
	logic [SLOT_W-1:0] best_i_q, prev_i_q;
	logic best_ok_q;
	logic [1:0] pend_rec_q;
	logic [3:0] pend_idx_q;
	logic [63:0] pend_addr_q, pend_val_q;
	logic [SLOT_W-1:0] scan_idx_s1;
	logic scan_v_s1;
	out_rec_t out_q;
	logic ov_q;

	logic [SLOT_W-1:0] raddr;
	logic [63:0] rd_addr, rd_cnt;
	logic rd_taken, t_we, t_clr;
	logic [SLOT_W-1:0] t_waddr;
	logic [63:0] t_wcnt;
	logic [2:0] region;
	logic [63:0] n_in;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [3:0] emit_idx;
	logic [63:0] emit_val;
	logic out_free, out_load, cand_ok;

	assign n_in = {52'd0, s_axis_tdata[75:64]};
	always_comb begin
		logic [63:0] p;
		p = s_axis_tdata[63:0];
		if (p >= kbase_q) region = 3'd0;
		else if (p >= ebase_q && p < hbase_q) region = 3'd1;
		else if (p >= hbase_q && p < hlim_q) region = 3'd2;
		else if (p < llim_q) region = 3'd3;
		else region = 3'd4;
	end

	// product mod 2^64 from three 32x32 partial products, high terms shifted up
	assign mul_a = (hstep_q == 2'd1) ? pc_q[63:32] : pc_q[31:0];
	assign mul_b = (hstep_q == 2'd2) ? HASH_MULT[63:32] : HASH_MULT[31:0];
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	assign emit_idx = (rec_q == 3'd0) ? 4'd0 : 4'(rec_q - 3'd1);
	always_comb begin
		case (rec_q)
			3'd1: emit_val = reg_cnt_q[0];
			3'd2: emit_val = reg_cnt_q[1];
			3'd3: emit_val = reg_cnt_q[2];
			3'd4: emit_val = reg_cnt_q[3];
			3'd5: emit_val = reg_cnt_q[4];
			default: emit_val = total_q;
		endcase
	end

	assign raddr = (state_q == ST_SCAN) ? scan_q : slot_q;
	assign t_we = (state_q == ST_CHECK) && (!rd_taken || rd_addr == pc_q);
	assign t_clr = (state_q == ST_CLEAR);
	assign t_waddr = slot_q;
	assign t_wcnt = (rd_taken ? rd_cnt : 64'd0) + n_q;

	rbhpp_table u_table (
		.clk(clk), .clr(t_clr), .raddr(raddr),
		.rd_addr(rd_addr), .rd_cnt(rd_cnt), .rd_taken(rd_taken),
		.we(t_we), .waddr(t_waddr), .wr_addr(pc_q), .wr_cnt(t_wcnt)
	);

	// a slot counts for this rank only if it ranks below the previous pick
	assign cand_ok = scan_v_s1 && rd_taken && rd_cnt > best_q && (rank_q == 4'd0 ||
		rd_cnt < prev_cnt_q || (rd_cnt == prev_cnt_q && scan_idx_s1 > prev_i_q));

	assign out_free = !ov_q || m_axis_tready;
	assign out_load = out_free && ((state_q == ST_EMIT && rec_q != 3'd5) ||
		(state_q == ST_SCAN_END && !scan_v_s1) || state_q == ST_DONE);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {1'b0, out_q.value, out_q.address, out_q.index,
		out_q.final_res, out_q.record};
	assign m_axis_tlast = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kbase_q <= RST_KERNEL_BASE;
			ebase_q <= RST_EXEC_BASE;
			hbase_q <= RST_HIGH_BASE;
			hlim_q <= RST_HIGH_LIMIT;
			llim_q <= RST_LOW_LIMIT;
			intv_q <= RST_INTERVAL;
			for (int i = 0; i < REGION_COUNT; i++) reg_cnt_q[i] <= '0;
			total_q <= '0;
			mark_q <= RST_INTERVAL;
			ov_q <= 1'b0;
			scan_v_s1 <= 1'b0;
			slot_q <= '0;
			hstep_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_KERNEL_BASE: kbase_q <= cfg_data;
					REG_EXEC_BASE:   ebase_q <= cfg_data;
					REG_HIGH_BASE:   hbase_q <= cfg_data;
					REG_HIGH_LIMIT:  hlim_q <= cfg_data;
					REG_LOW_LIMIT:   llim_q <= cfg_data;
					REG_INTERVAL:    intv_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) ov_q <= 1'b1;
			else if (ov_q && m_axis_tready) ov_q <= 1'b0;
			// the compare runs in the cycle after the table read
			scan_v_s1 <= (state_q == ST_SCAN);
			scan_idx_s1 <= scan_q;
			unique case (state_q)
				ST_CLEAR: begin
					if (slot_q == '1) state_q <= ST_IDLE;
					slot_q <= slot_q + SLOT_W'(1);
				end
				ST_IDLE: if (s_axis_tvalid) begin
					pc_q <= s_axis_tdata[63:0];
					n_q <= n_in;
					rec_q <= '0;
					if (s_axis_tuser) begin
						fin_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						fin_q <= 1'b0;
						reg_cnt_q[region] <= reg_cnt_q[region] + n_in;
						total_q <= total_q + n_in;
						state_q <= (region == 3'd0) ? ST_HASH : ST_MARK;
					end
				end
				ST_HASH: begin
					if (hstep_q == 2'd0) prod_q <= mul_p;
					else prod_q <= prod_q + {mul_p[31:0], 32'd0};
					if (hstep_q == 2'd2) begin
						hstep_q <= 2'd0;
						state_q <= ST_PROBE;
					end else begin
						hstep_q <= hstep_q + 2'd1;
					end
				end
				ST_PROBE: begin
					slot_q <= prod_q[HASH_SHIFT +: SLOT_W];
					probes_q <= '0;
					state_q <= ST_WAIT;
				end
				ST_WAIT: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (t_we || probes_q == '1) begin
						state_q <= ST_MARK;
					end else begin
						probes_q <= probes_q + SLOT_W'(1);
						slot_q <= slot_q + SLOT_W'(1);
						state_q <= ST_WAIT;
					end
				end
				ST_MARK: begin
					if (total_q >= mark_q) begin
						mark_q <= total_q + intv_q;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (rec_q == 3'd5) begin
						// last region record waits until we know if a hot record follows
						pend_rec_q <= REC_REGION;
						pend_idx_q <= emit_idx;
						pend_addr_q <= '0;
						pend_val_q <= emit_val;
						rank_q <= '0;
						scan_q <= '0;
						best_q <= '0;
						best_ok_q <= 1'b0;
						state_q <= ST_SCAN;
					end else if (out_free) begin
						out_q.final_res <= fin_q;
						out_q.address <= '0;
						out_q.last <= 1'b0;
						out_q.index <= emit_idx;
						out_q.record <= (rec_q == 3'd0) ? REC_TOTAL : REC_REGION;
						out_q.value <= emit_val;
						rec_q <= rec_q + 3'd1;
					end
				end
				ST_SCAN: begin
					if (cand_ok) begin
						best_q <= rd_cnt;
						best_addr_q <= rd_addr;
						best_i_q <= scan_idx_s1;
						best_ok_q <= 1'b1;
					end
					if (scan_q == '1) state_q <= ST_SCAN_END;
					else scan_q <= scan_q + SLOT_W'(1);
				end
				ST_SCAN_END: begin
					if (scan_v_s1) begin
						if (cand_ok) begin
							best_q <= rd_cnt;
							best_addr_q <= rd_addr;
							best_i_q <= scan_idx_s1;
							best_ok_q <= 1'b1;
						end
					end else if (out_free) begin
						out_q.record <= pend_rec_q;
						out_q.final_res <= fin_q;
						out_q.index <= pend_idx_q;
						out_q.address <= pend_addr_q;
						out_q.value <= pend_val_q;
						out_q.last <= !best_ok_q;
						if (!best_ok_q) begin
							state_q <= ST_IDLE;
						end else begin
							pend_rec_q <= REC_HOT;
							pend_idx_q <= rank_q;
							pend_addr_q <= best_addr_q;
							pend_val_q <= best_q;
							prev_cnt_q <= best_q;
							prev_i_q <= best_i_q;
							if (rank_q == 4'(TOP_RANKS - 1)) begin
								state_q <= ST_DONE;
							end else begin
								rank_q <= rank_q + 4'd1;
								scan_q <= '0;
								best_q <= '0;
								best_ok_q <= 1'b0;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_DONE: if (out_free) begin
					out_q.record <= pend_rec_q;
					out_q.final_res <= fin_q;
					out_q.index <= pend_idx_q;
					out_q.address <= pend_addr_q;
					out_q.value <= pend_val_q;
					out_q.last <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/rbhpp_checker.sv =====
// ---------------------------------------------------------------------------
// rbhpp_port_checks
// port level checks of the profiler
// ---------------------------------------------------------------------------
`include "region_bucketed_hot_pc_profiler_assert.svh"
module rbhpp_port_checks
	import rbhpp_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [135:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	logic [1:0] rec_code;
	logic       out_wait, out_mid, out_end;

	assign rec_code = m_axis_tdata[1:0];
	assign out_wait = m_axis_tvalid && !m_axis_tready;
	assign out_mid = m_axis_tvalid && !m_axis_tlast;
	assign out_end = m_axis_tvalid && m_axis_tlast;

	`RBP_ASSERT_NXT(a_out_hold, clk, arst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
	`RBP_ASSERT_IMP(a_no_req_while_out, clk, arst_n, out_mid, !s_axis_tready)
	`RBP_ASSERT_IMP(a_rec_code, clk, arst_n, m_axis_tvalid, rec_code != 2'd3)
	`RBP_ASSERT_IMP(a_last_kind, clk, arst_n, out_end, rec_code == REC_HOT || rec_code == REC_REGION)

endmodule

bind region_bucketed_hot_pc_profiler rbhpp_port_checks u_rbhpp_port_checks (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast)
);

// ===== tb/sv/rbhpp_checker.sv =====
// ---------------------------------------------------------------------------
// rbhpp_checker
// watches the request, result and register channels of the profiler, keeps
// its own copy of the region counters and hot slot table, and compares every
// result record against the oldest predicted one
// ---------------------------------------------------------------------------
module rbhpp_checker
	import rbhpp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,   // pc[63:0], insn_count[75:64], zero fill
	input  logic         s_axis_tuser,   // kind
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [135:0] m_axis_tdata,   // record, final_res, index, address, value
	input  logic         m_axis_tlast,   // last
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [63:0]  cfg_data,
	output int           mismatches,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_REPORT = 1'b1;

	logic [63:0] kernel_lo, exec_lo, high_lo, high_hi, low_hi, interval;
	logic [63:0] region_sum [REGION_COUNT];
	logic [63:0] total_sum, next_mark;
	logic [63:0] slot_pc [TABLE_SLOTS];
	logic [63:0] slot_sum [TABLE_SLOTS];
	bit          slot_used [TABLE_SLOTS];
	out_rec_t    report_q [$];
	int          bad_cnt;

	assign mismatches = bad_cnt;

	function automatic int region_for(input logic [63:0] pc);
		if (pc >= kernel_lo) return 0;
		if (pc >= exec_lo && pc < high_lo) return 1;
		if (pc >= high_lo && pc < high_hi) return 2;
		if (pc < low_hi) return 3;
		return 4;
	endfunction

	task automatic count_slot(input logic [63:0] pc, input logic [63:0] n);
		logic [63:0] prod;
		logic [SLOT_W-1:0] home, s;
		prod = pc * HASH_MULT;
		home = prod[HASH_SHIFT +: SLOT_W];
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			s = home + k[SLOT_W-1:0];
			if (slot_used[s] && slot_pc[s] == pc) begin
				slot_sum[s] += n;
				return;
			end
			if (!slot_used[s]) begin
				slot_used[s] = 1'b1;
				slot_pc[s] = pc;
				slot_sum[s] += n;
				return;
			end
		end
		// table full: the address stays uncounted
	endtask

	function automatic out_rec_t make_rec(input logic [1:0] rec, input logic fin,
			input int idx, input logic [63:0] addr, input logic [63:0] val);
		out_rec_t r;
		r.record = rec;
		r.final_res = fin;
		r.index = idx[3:0];
		r.address = addr;
		r.value = val;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic predict_report(input logic fin);
		bit taken_rank [TABLE_SLOTS];
		logic [63:0] best;
		int pick;
		out_rec_t r;
		foreach (taken_rank[i]) taken_rank[i] = 1'b0;
		report_q.push_back(make_rec(REC_TOTAL, fin, 0, 64'd0, total_sum));
		for (int i = 0; i < REGION_COUNT; i++)
			report_q.push_back(make_rec(REC_REGION, fin, i, 64'd0, region_sum[i]));
		for (int rank = 0; rank < TOP_RANKS; rank++) begin
			best = 64'd0;
			pick = -1;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (!taken_rank[i] && slot_sum[i] > best) begin
					best = slot_sum[i];
					pick = i;
				end
			end
			if (pick < 0) break;
			taken_rank[pick] = 1'b1;
			report_q.push_back(make_rec(REC_HOT, fin, rank, slot_pc[pick], best));
		end
		r = report_q.pop_back();
		r.last = 1'b1;
		report_q.push_back(r);
	endtask

	task automatic take_request(input logic kind, input logic [63:0] pc, input logic [11:0] n);
		int reg_no;
		if (kind == KIND_REPORT) begin
			predict_report(1'b1);
			return;
		end
		reg_no = region_for(pc);
		region_sum[reg_no] += {52'd0, n};
		total_sum += {52'd0, n};
		if (reg_no == 0) count_slot(pc, {52'd0, n});
		if (total_sum >= next_mark) begin
			next_mark = total_sum + interval;
			predict_report(1'b0);
		end
	endtask

	task automatic check_result();
		out_rec_t got, want;
		got.record = m_axis_tdata[1:0];
		got.final_res = m_axis_tdata[2];
		got.index = m_axis_tdata[6:3];
		got.address = m_axis_tdata[70:7];
		got.value = m_axis_tdata[134:71];
		got.last = m_axis_tlast;
		if (report_q.size() == 0) begin
			bad_cnt++;
			if (bad_cnt <= 10)
				$display("mismatch: unexpected record rec=%0d idx=%0d addr=%h val=%h",
					got.record, got.index, got.address, got.value);
			return;
		end
		want = report_q.pop_front();
		if (got !== want) begin
			bad_cnt++;
			if (bad_cnt <= 10) begin
				$display("mismatch: exp rec=%0d fin=%0d idx=%0d addr=%h val=%h last=%0d",
					want.record, want.final_res, want.index, want.address, want.value,
					want.last);
				$display("          got rec=%0d fin=%0d idx=%0d addr=%h val=%h last=%0d",
					got.record, got.final_res, got.index, got.address, got.value,
					got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_lo = RST_KERNEL_BASE;
			exec_lo = RST_EXEC_BASE;
			high_lo = RST_HIGH_BASE;
			high_hi = RST_HIGH_LIMIT;
			low_hi = RST_LOW_LIMIT;
			interval = RST_INTERVAL;
			foreach (region_sum[i]) region_sum[i] = 64'd0;
			total_sum = 64'd0;
			next_mark = RST_INTERVAL;
			foreach (slot_pc[i]) begin
				slot_pc[i] = 64'd0;
				slot_sum[i] = 64'd0;
				slot_used[i] = 1'b0;
			end
			report_q.delete();
			bad_cnt = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_KERNEL_BASE: kernel_lo = cfg_data;
					REG_EXEC_BASE:   exec_lo = cfg_data;
					REG_HIGH_BASE:   high_lo = cfg_data;
					REG_HIGH_LIMIT:  high_hi = cfg_data;
					REG_LOW_LIMIT:   low_hi = cfg_data;
					REG_INTERVAL:    interval = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) check_result();
			if (s_axis_tvalid && s_axis_tready)
				take_request(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[75:64]);
			pending <= report_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// stimulus for the region bucketed hot address profiler: directed boundary
// and report requests, edge report intervals, randomized region setups and
// a burst of repeated kernel addresses
// ---------------------------------------------------------------------------
module tb_top;
	import rbhpp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_REPORT = 1'b1;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [79:0]  s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [135:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_we;
	logic [2:0]   cfg_idx;
	logic [63:0]  cfg_data;
	int           mismatches;
	int           pending;

	int          stall_reqs;
	int          stalls_done;
	bit          no_gaps;
	logic [63:0] bound [5];
	logic [63:0] kpool [24];

	region_bucketed_hot_pc_profiler i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	rbhpp_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#500ms;
		$display("FAILURE");
		$finish;
	end

	// result side: random readiness, plus long hold-offs on request
	initial begin
		int run_left;
		int mode;
		run_left = 0;
		mode = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_reqs != stalls_done) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				stalls_done++;
			end else begin
				if (run_left == 0) begin
					mode = $urandom_range(0, 19);
					run_left = (mode == 19) ? $urandom_range(100, 400) : $urandom_range(10, 200);
				end
				run_left--;
				if (mode == 19) m_axis_tready <= 1'b0;
				else if (mode < 6) m_axis_tready <= 1'b1;
				else if (mode < 14) m_axis_tready <= ($urandom_range(0, 3) != 0);
				else m_axis_tready <= ($urandom_range(0, 9) < 3);
			end
		end
	end

	function automatic int next_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(15, 120);
	endfunction

	task automatic send(input logic kind, input logic [63:0] pc, input logic [11:0] n);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {4'd0, n, pc};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// hold off new requests until every predicted record is back, then let an
	// event still probing the table run out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4000) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup_regions(input logic [63:0] kb, input logic [63:0] eb,
			input logic [63:0] hb, input logic [63:0] hl, input logic [63:0] ll,
			input logic [63:0] iv);
		write_reg(REG_KERNEL_BASE, kb);
		write_reg(REG_EXEC_BASE, eb);
		write_reg(REG_HIGH_BASE, hb);
		write_reg(REG_HIGH_LIMIT, hl);
		write_reg(REG_LOW_LIMIT, ll);
		write_reg(REG_INTERVAL, iv);
		bound[0] = kb; bound[1] = eb; bound[2] = hb; bound[3] = hl; bound[4] = ll;
		foreach (kpool[i]) kpool[i] = kb + {48'd0, 16'($urandom_range(0, 65535))};
	endtask

	function automatic logic [11:0] rand_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 12'd0;
		if (r == 1) return 12'hFFF;
		return 12'($urandom_range(0, 4095));
	endfunction

	task automatic random_run(input int count, input bit with_stall);
		int r;
		logic [63:0] pc;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if (with_stall && i == 20) begin
				// long hold-off on results while requests keep coming
				stall_reqs++;
				send(KIND_REPORT, {$urandom, $urandom}, 12'($urandom));
				continue;
			end
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send(KIND_REPORT, {$urandom, $urandom}, 12'($urandom));
				continue;
			end
			if (r < 45) pc = kpool[$urandom_range(0, 23)];
			else if (r < 80) pc = bound[$urandom_range(0, 4)] + 64'($urandom_range(0, 4)) - 64'd2;
			else pc = {$urandom, $urandom};
			send(KIND_EVENT, pc, rand_count());
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		logic [63:0] eb, hb;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = KIND_EVENT;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_KERNEL_BASE;
		cfg_data = '0;
		stall_reqs = 0;
		stalls_done = 0;
		no_gaps = 1'b0;
		bound[0] = RST_KERNEL_BASE; bound[1] = RST_EXEC_BASE; bound[2] = RST_HIGH_BASE;
		bound[3] = RST_HIGH_LIMIT; bound[4] = RST_LOW_LIMIT;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset values: empty table report first, then each region edge
		send(KIND_REPORT, 64'd0, 12'd0);
		send(KIND_EVENT, 64'h0000_0050_0000_0000, 12'd100);
		send(KIND_EVENT, 64'd0, 12'hFFF);
		send(KIND_EVENT, RST_LOW_LIMIT - 64'd1, 12'd3);
		send(KIND_EVENT, RST_EXEC_BASE, 12'd0);
		send(KIND_EVENT, RST_HIGH_BASE - 64'd1, 12'd5);
		send(KIND_EVENT, RST_HIGH_BASE, 12'd6);
		send(KIND_EVENT, RST_HIGH_LIMIT - 64'd1, 12'd7);
		send(KIND_EVENT, RST_HIGH_LIMIT, 12'd8);
		send(KIND_EVENT, RST_KERNEL_BASE - 64'd1, 12'd9);
		send(KIND_EVENT, RST_KERNEL_BASE, 12'd11);
		send(KIND_EVENT, ALL_ONES, 12'hFFF);
		send(KIND_EVENT, RST_KERNEL_BASE + 64'd16, 12'd11);
		send(KIND_EVENT, RST_KERNEL_BASE + 64'd16, 12'd1);
		send(KIND_REPORT, ALL_ONES, 12'hFFF);
		drain();
		// indexes past the last register change nothing
		write_reg(REG_SPARE_LO, ALL_ONES);
		write_reg(REG_SPARE_HI, 64'd0);
		send(KIND_EVENT, 64'd0, 12'd2);
		send(KIND_REPORT, 64'd0, 12'd0);
		drain();

		// only all-ones is kernel; low region covers almost everything
		setup_regions(ALL_ONES, 64'd0, 64'h1000, 64'h2000, ALL_ONES, 64'd60000);
		send(KIND_EVENT, ALL_ONES, 12'd1);
		send(KIND_EVENT, 64'd0, 12'd2);
		send(KIND_EVENT, 64'h1000, 12'd3);
		send(KIND_EVENT, 64'h3000, 12'd4);
		drain();

		// zero interval: the pending mark stays where it is
		write_reg(REG_INTERVAL, 64'd0);
		for (int i = 0; i < 16; i++) send(KIND_EVENT, 64'h1800, 12'hFFF);
		send(KIND_EVENT, 64'h1800, 12'd0);
		send(KIND_EVENT, 64'h1800, 12'd0);
		drain();
		// largest interval, also without moving the pending mark
		write_reg(REG_INTERVAL, ALL_ONES);
		send(KIND_EVENT, ALL_ONES, 12'd1);
		send(KIND_EVENT, ALL_ONES, 12'd1);
		drain();
		write_reg(REG_INTERVAL, 64'd60000);
		send(KIND_EVENT, 64'h0, 12'd1);
		drain();

		setup_regions(RST_KERNEL_BASE, RST_EXEC_BASE, RST_HIGH_BASE, RST_HIGH_LIMIT,
			RST_LOW_LIMIT, 64'd80000);
		random_run(110, 1'b1);
		drain();

		for (int p = 0; p < 2; p++) begin
			eb = {$urandom, $urandom};
			hb = eb + {32'd0, $urandom};
			setup_regions(($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : 64'hFFF0_0000_0000_0000,
				eb, hb, hb + {32'd0, $urandom}, {24'd0, $urandom, 8'($urandom)},
				64'($urandom_range(60000, 200000)));
			random_run(110, p == 1);
			drain();
		end

		// every address is kernel; a burst of repeated addresses back to back
		write_reg(REG_KERNEL_BASE, 64'd0);
		no_gaps = 1'b1;
		for (int i = 0; i < 30; i++)
			send(KIND_EVENT, 64'hA5A5_0000_0000_0000 + 64'(i % 7), 12'(i * 37));
		no_gaps = 1'b0;
		for (int i = 0; i < 4; i++) send(KIND_EVENT, 64'h5A5A_0000_0000_0000 + 64'(i), 12'd7);
		send(KIND_EVENT, kpool[0], 12'd9);
		send(KIND_REPORT, 64'd0, 12'd0);
		drain();

		if (mismatches == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
